### rtl/hvt_pkg.sv
// shared types and constants for the homogeneous vector transform
`default_nettype none

package hvt_pkg;

  // data and coefficient format
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned PROD_W            = 2 * DATA_W;
  localparam int unsigned PAIR_W            = PROD_W + 1;
  localparam int unsigned SUM_W             = PROD_W + 2;
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // matrix geometry
  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned NUM_COLS = 4;
  localparam int unsigned NUM_REGS = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // register reset values give the identity in Q16.16
  localparam logic [CFG_DATA_W-1:0] RST_R0_C01 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_R0_C23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_R1_C01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_R1_C23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_R2_C01 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_R2_C23 = 64'h0000_0000_0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0_C01 = 3'd0,
    CFG_R0_C23 = 3'd1,
    CFG_R1_C01 = 3'd2,
    CFG_R1_C23 = 3'd3,
    CFG_R2_C01 = 3'd4,
    CFG_R2_C23 = 3'd5
  } cfg_reg_e;

  // four coefficients of one matrix row, column 0 in the low slot
  typedef logic [NUM_COLS-1:0][DATA_W-1:0] row_coef_t;

  // per-stage load enables, shared by all row datapaths
  typedef struct packed {
    logic ld_mul;
    logic ld_pair;
    logic ld_sum;
    logic ld_out;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

### rtl/hvt_cfg.sv
// coefficient register file, six 64-bit registers unpacked into matrix rows
`default_nettype none

module hvt_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [hvt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [hvt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output hvt_pkg::row_coef_t                     coef_o [hvt_pkg::NUM_ROWS]
);

  logic [hvt_pkg::CFG_DATA_W-1:0] regs_q [hvt_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= hvt_pkg::RST_R0_C01;
      regs_q[1] <= hvt_pkg::RST_R0_C23;
      regs_q[2] <= hvt_pkg::RST_R1_C01;
      regs_q[3] <= hvt_pkg::RST_R1_C23;
      regs_q[4] <= hvt_pkg::RST_R2_C01;
      regs_q[5] <= hvt_pkg::RST_R2_C23;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hvt_pkg::CFG_R0_C01: regs_q[0] <= cfg_data_i;
        hvt_pkg::CFG_R0_C23: regs_q[1] <= cfg_data_i;
        hvt_pkg::CFG_R1_C01: regs_q[2] <= cfg_data_i;
        hvt_pkg::CFG_R1_C23: regs_q[3] <= cfg_data_i;
        hvt_pkg::CFG_R2_C01: regs_q[4] <= cfg_data_i;
        hvt_pkg::CFG_R2_C23: regs_q[5] <= cfg_data_i;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // low half is the even column, high half the odd column
  always_comb begin
    for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
      coef_o[r][0] = regs_q[2*r][hvt_pkg::DATA_W-1:0];
      coef_o[r][1] = regs_q[2*r][hvt_pkg::CFG_DATA_W-1:hvt_pkg::DATA_W];
      coef_o[r][2] = regs_q[2*r+1][hvt_pkg::DATA_W-1:0];
      coef_o[r][3] = regs_q[2*r+1][hvt_pkg::CFG_DATA_W-1:hvt_pkg::DATA_W];
    end
  end

endmodule

`default_nettype wire

### rtl/hvt_row.sv
// one matrix row: multiply, pair add, final add, shift and saturate
`default_nettype none

module hvt_row #(
  parameter int unsigned FRAC_BITS = hvt_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire hvt_pkg::pipe_ctrl_t                ctrl_i,
  input  wire logic signed [hvt_pkg::DATA_W-1:0]  vec_i [hvt_pkg::NUM_COLS],
  input  wire hvt_pkg::row_coef_t                 coef_i,
  output logic        [hvt_pkg::DATA_W-1:0]       res_o,
  output logic                                    ovf_o
);

  localparam int unsigned DW = hvt_pkg::DATA_W;
  localparam int unsigned PW = hvt_pkg::PROD_W;
  localparam int unsigned AW = hvt_pkg::PAIR_W;
  localparam int unsigned SW = hvt_pkg::SUM_W;

  logic signed [PW-1:0] prod_q [hvt_pkg::NUM_COLS];
  logic signed [AW-1:0] pair_q [2];
  logic signed [SW-1:0] sum_q;
  logic signed [SW-1:0] shifted;
  logic [SW-DW:0]       upper;
  logic                 fits;
  logic [DW-1:0]        res_d, res_q;
  logic                 ovf_d, ovf_q;

  // stage 1: four independent 32x32 products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_mul) begin
      for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
        prod_q[c] <= $signed(coef_i[c]) * vec_i[c];
      end
    end
  end

  // stage 2: pairwise sums
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_pair) begin
      pair_q[0] <= AW'(prod_q[0]) + AW'(prod_q[1]);
      pair_q[1] <= AW'(prod_q[2]) + AW'(prod_q[3]);
    end
  end

  // stage 3: exact four-term sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_sum) begin
      sum_q <= SW'(pair_q[0]) + SW'(pair_q[1]);
    end
  end

  // stage 4: floor shift and clamp to 32 bits
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    upper   = shifted[SW-1:DW-1];
    fits    = (&upper) | (~|upper);
    ovf_d   = ~fits;
    if (fits) begin
      res_d = shifted[DW-1:0];
    end else if (shifted[SW-1]) begin
      res_d = hvt_pkg::SAT_MIN;
    end else begin
      res_d = hvt_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_out) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

### rtl/homogeneous_vector_transform.sv
// top level: 3x4 affine transform of homogeneous vectors, three output rows
//
// input channel: in_valid_i / in_stall_o carry one vector x, y, z, w per
// transaction, signed fixed point with FRAC_BITS fraction bits.
// output channel: out_valid_o / out_stall_i carry the transformed x, y, z
// and an overflow flag set when any component was clamped to 32 bits.
// configuration: cfg_valid_i / cfg_ready_o write one 64-bit register of
// two packed coefficients per transaction; ready is always high, indexes
// above the last register are dropped. write only while the pipe is empty.
// pipeline: an accepted vector passes through the multiply, pair add, final add
// and shift/saturate stages in turn.
// throughput: one vector per cycle while the output is not stalled, with four
// register stages holding the 32x32 multiplies, pair adds, wide add and clamp.
// reset: all stage valids clear, coefficients return to the identity.
// stall: each stage holds its contents while the next stage is full and
// blocked; empty stages still fill, so bubbles collapse and the input is
// stalled only once all four stages are occupied behind a stalled output.
`default_nettype none

module homogeneous_vector_transform #(
  parameter int unsigned FRAC_BITS = hvt_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [hvt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [hvt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input vector channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [hvt_pkg::DATA_W-1:0] in_x_i,
  input  wire logic signed [hvt_pkg::DATA_W-1:0] in_y_i,
  input  wire logic signed [hvt_pkg::DATA_W-1:0] in_z_i,
  input  wire logic signed [hvt_pkg::DATA_W-1:0] in_w_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [hvt_pkg::DATA_W-1:0]      out_x_o,
  output logic signed [hvt_pkg::DATA_W-1:0]      out_y_o,
  output logic signed [hvt_pkg::DATA_W-1:0]      out_z_o,
  output logic                                   overflow_o
);

  localparam int unsigned NSTG = 4;

  hvt_pkg::row_coef_t          coef [hvt_pkg::NUM_ROWS];
  logic signed [hvt_pkg::DATA_W-1:0] vec [hvt_pkg::NUM_COLS];
  logic [hvt_pkg::DATA_W-1:0]  res [hvt_pkg::NUM_ROWS];
  logic [hvt_pkg::NUM_ROWS-1:0] ovf;
  hvt_pkg::pipe_ctrl_t         ctrl;
  logic [NSTG-1:0]             ld;
  logic [NSTG-1:0]             vld_d, vld_q;

  // ready is tied high, so the registers accept every write
  assign cfg_ready_o = 1'b1;

  hvt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // stage loads when empty or when its contents move on; last stage moves
  // on when the receiver takes the transaction
  always_comb begin
    ld[NSTG-1] = ~vld_q[NSTG-1] | ~out_stall_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      ld[s] = ~vld_q[s] | ld[s+1];
    end
    vld_d[0] = ld[0] ? in_valid_i : vld_q[0];
    for (int s = 1; s < NSTG; s++) begin
      vld_d[s] = ld[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl.ld_mul  = ld[0];
  assign ctrl.ld_pair = ld[1];
  assign ctrl.ld_sum  = ld[2];
  assign ctrl.ld_out  = ld[3];

  assign in_stall_o = ~ld[0];

  assign vec[0] = in_x_i;
  assign vec[1] = in_y_i;
  assign vec[2] = in_z_i;
  assign vec[3] = in_w_i;

  // one datapath per output row, all sharing the stage enables
  for (genvar r = 0; r < hvt_pkg::NUM_ROWS; r++) begin : g_row
    hvt_row #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .vec_i  (vec),
      .coef_i (coef[r]),
      .res_o  (res[r]),
      .ovf_o  (ovf[r])
    );
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_x_o     = res[0];
  assign out_y_o     = res[1];
  assign out_z_o     = res[2];
  assign overflow_o  = |ovf;

  // an accepted transaction always lands in the first stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transaction missing from first stage");

  // input stalls only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // a blocked middle stage keeps its transaction
  a_hold_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !ld[3] |=> vld_q[2])
    else $error("blocked sum stage lost its transaction");

  // overflow flag only with a clamped component
  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      (out_x_o == hvt_pkg::SAT_MAX) || (out_x_o == hvt_pkg::SAT_MIN) ||
      (out_y_o == hvt_pkg::SAT_MAX) || (out_y_o == hvt_pkg::SAT_MIN) ||
      (out_z_o == hvt_pkg::SAT_MAX) || (out_z_o == hvt_pkg::SAT_MIN))
    else $error("overflow flagged without a saturated component");

endmodule

`default_nettype wire
